### rtl/srp_pkg.sv
// Shared types and constants for the spatial region prefetcher.
// No dependencies; every other rtl file refers to this package by scope.
`default_nettype none

package srp_pkg;

  // Default geometry
  localparam int TableEntriesDef   = 16;
  localparam int LinesPerRegionDef = 16;
  localparam int LineOffsetBitsDef = 6;
  localparam int AddrBitsDef       = 32;

  // Fixed field widths
  localparam int DataW  = 32;
  localparam int AgeW   = 32;
  localparam int ThrW   = 5;
  localparam int PaddrW = 3;

  // Configuration registers
  localparam logic [ThrW-1:0] ThresholdReset = 5'd8;
  localparam logic            CfgThresholdIdx = 1'b0;

  typedef enum logic [2:0] {
    FE_IDLE,
    FE_SCAN,
    FE_UPDATE,
    FE_EVAL,
    FE_PUSH
  } front_state_e;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

`default_nettype wire

### rtl/srp_front.sv
// Front end: accepts a miss, scans the region table, updates the entry and
// queues a prefetch job for a covered, not full region. Depends on srp_pkg.
`default_nettype none

module srp_front #(
  parameter int TableEntries   = srp_pkg::TableEntriesDef,
  parameter int LinesPerRegion = srp_pkg::LinesPerRegionDef,
  parameter int LineOffsetBits = srp_pkg::LineOffsetBitsDef,
  parameter int AddrBits       = srp_pkg::AddrBitsDef,
  localparam int RegionBits    = $clog2(LinesPerRegion),
  localparam int Shift         = LineOffsetBits + RegionBits,
  localparam int TagW          = AddrBits - Shift,
  localparam int IdxW          = (TableEntries > 1) ? $clog2(TableEntries) : 1
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [srp_pkg::DataW-1:0]   miss_address_i,
  input  wire logic [srp_pkg::ThrW-1:0]    threshold_i,
  input  wire srp_pkg::queue_status_t      qstat_i,
  output logic                             push_o,
  output logic [TagW-1:0]                  job_tag_o,
  output logic [LinesPerRegion-1:0]        job_mask_o,
  output logic                             busy_o
);

  srp_pkg::front_state_e state_q, state_d;

  logic [TableEntries-1:0]   valid_q;
  logic [TagW-1:0]           tag_q  [TableEntries];
  logic [LinesPerRegion-1:0] bmap_q [TableEntries];
  logic [srp_pkg::AgeW-1:0]  age_q  [TableEntries];
  logic [srp_pkg::AgeW-1:0]  age_cnt_q;

  logic [TagW-1:0]           miss_tag_q;
  logic [RegionBits-1:0]     miss_line_q;
  logic [IdxW-1:0]           scan_q;
  logic                      found_q, inv_found_q;
  logic [IdxW-1:0]           hit_idx_q, inv_idx_q, min_idx_q, sel_idx_q;
  logic [srp_pkg::AgeW-1:0]  min_age_q;
  logic [LinesPerRegion-1:0] bv_q;

  logic [AddrBits+srp_pkg::DataW-1:0] addr_wide;
  logic [AddrBits-1:0]       addr;
  logic                      accept;
  logic                      scan_last;
  logic                      scan_hit, scan_inv, scan_older;
  logic [IdxW-1:0]           sel_idx;
  logic [LinesPerRegion-1:0] old_bm, line_bit, new_bm;
  logic [5:0]                set_cnt;
  logic                      covered;

  assign addr_wide = {{AddrBits{1'b0}}, miss_address_i};
  assign addr      = addr_wide[AddrBits-1:0];
  assign accept    = start_i && (state_q == srp_pkg::FE_IDLE);
  assign scan_last = (scan_q == IdxW'(TableEntries - 1));

  assign scan_hit   = valid_q[scan_q] && (tag_q[scan_q] == miss_tag_q);
  assign scan_inv   = !valid_q[scan_q];
  assign scan_older = (age_q[scan_q] < min_age_q);

  // Hit wins, then the first free entry, then the oldest entry
  assign sel_idx = found_q ? hit_idx_q : (inv_found_q ? inv_idx_q : min_idx_q);
  assign old_bm  = found_q ? bmap_q[sel_idx] : '0;

  always_comb begin
    line_bit = '0;
    if ({1'b0, miss_line_q} < (RegionBits+1)'(LinesPerRegion)) begin
      line_bit = LinesPerRegion'(1) << miss_line_q;
    end
  end
  assign new_bm = old_bm | line_bit;

  assign set_cnt = 6'($countones(bv_q));
  assign covered = (set_cnt >= {1'b0, threshold_i});

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      srp_pkg::FE_IDLE:   if (start_i) state_d = srp_pkg::FE_SCAN;
      srp_pkg::FE_SCAN:   if (scan_last) state_d = srp_pkg::FE_UPDATE;
      srp_pkg::FE_UPDATE: state_d = srp_pkg::FE_EVAL;
      srp_pkg::FE_EVAL: begin
        if (covered && (bv_q != '1)) state_d = srp_pkg::FE_PUSH;
        else state_d = srp_pkg::FE_IDLE;
      end
      srp_pkg::FE_PUSH:   if (!qstat_i.full) state_d = srp_pkg::FE_IDLE;
      default:            state_d = srp_pkg::FE_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    busy_o = 1'b1;
    push_o = 1'b0;
    unique case (state_q)
      srp_pkg::FE_IDLE: busy_o = 1'b0;
      srp_pkg::FE_PUSH: push_o = !qstat_i.full;
      default:          busy_o = 1'b1;
    endcase
  end

  assign job_tag_o  = miss_tag_q;
  assign job_mask_o = ~bv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= srp_pkg::FE_IDLE;
      valid_q   <= '0;
      age_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == srp_pkg::FE_UPDATE) begin
        valid_q[sel_idx] <= 1'b1;
        age_cnt_q        <= age_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      miss_tag_q  <= addr[AddrBits-1:Shift];
      miss_line_q <= addr[Shift-1:LineOffsetBits];
      scan_q      <= '0;
      found_q     <= 1'b0;
      inv_found_q <= 1'b0;
    end
    if (state_q == srp_pkg::FE_SCAN) begin
      scan_q <= scan_q + 1'b1;
      if (scan_hit && !found_q) begin
        found_q   <= 1'b1;
        hit_idx_q <= scan_q;
      end
      if (scan_inv && !inv_found_q) begin
        inv_found_q <= 1'b1;
        inv_idx_q   <= scan_q;
      end
      // Strict compare keeps the lowest index on equal ages
      if ((scan_q == '0) || scan_older) begin
        min_idx_q <= scan_q;
        min_age_q <= age_q[scan_q];
      end
    end
    if (state_q == srp_pkg::FE_UPDATE) begin
      tag_q[sel_idx]  <= miss_tag_q;
      bmap_q[sel_idx] <= new_bm;
      age_q[sel_idx]  <= age_cnt_q + 1'b1;
      bv_q            <= new_bm;
      sel_idx_q       <= sel_idx;
    end
    // Mark every line of a covered region as fetched
    if ((state_q == srp_pkg::FE_EVAL) && covered) begin
      bmap_q[sel_idx_q] <= '1;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == srp_pkg::FE_UPDATE) |-> ($past(state_q) == srp_pkg::FE_SCAN))
    else $error("table update without a completed scan");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != srp_pkg::FE_UPDATE) |=> $stable(age_cnt_q))
    else $error("age counter moved outside an update");

endmodule

`default_nettype wire

### rtl/srp_queue.sv
// Two-entry job queue between the table front end and the emitter.
// Depends on srp_pkg for the status struct.
`default_nettype none

module srp_queue #(
  parameter int Width = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire logic [Width-1:0]   data_i,
  input  wire logic               pop_i,
  output logic [Width-1:0]        data_o,
  output srp_pkg::queue_status_t  status_o
);

  logic [Width-1:0] slot_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       count_q;

  assign status_o.full  = (count_q == 2'd2);
  assign status_o.empty = (count_q == 2'd0);
  assign data_o         = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= data_i;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && status_o.full) && !(pop_i && status_o.empty))
    else $error("job queue overflow or underflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (count_q == $past(count_q) + 2'd1))
    else $error("job queue count lost a push");

endmodule

`default_nettype wire

### rtl/srp_back.sv
// Emitter: takes one job from the queue and issues one prefetch address
// per cycle for each marked line, lowest line first. Depends on srp_pkg.
`default_nettype none

module srp_back #(
  parameter int LinesPerRegion = srp_pkg::LinesPerRegionDef,
  parameter int LineOffsetBits = srp_pkg::LineOffsetBitsDef,
  parameter int AddrBits       = srp_pkg::AddrBitsDef,
  localparam int RegionBits    = $clog2(LinesPerRegion),
  localparam int Shift         = LineOffsetBits + RegionBits,
  localparam int TagW          = AddrBits - Shift
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire srp_pkg::queue_status_t     qstat_i,
  input  wire logic [TagW-1:0]            job_tag_i,
  input  wire logic [LinesPerRegion-1:0]  job_mask_i,
  output logic                            pop_o,
  output logic                            result_valid_o,
  output logic [srp_pkg::DataW-1:0]       prefetch_address_o,
  output logic                            last_in_run_o
);

  logic                      active_q;
  logic [TagW-1:0]           tag_q;
  logic [LinesPerRegion-1:0] mask_q;
  logic                      valid_q, last_q;
  logic [srp_pkg::DataW-1:0] addr_q;

  logic [RegionBits-1:0]     low_idx;
  logic [LinesPerRegion-1:0] rest;
  logic [AddrBits+srp_pkg::DataW-1:0] full_addr;

  assign pop_o = !active_q && !qstat_i.empty;

  always_comb begin
    low_idx = '0;
    for (int i = LinesPerRegion - 1; i >= 0; i--) begin
      if (mask_q[i]) low_idx = RegionBits'(i);
    end
  end

  assign rest      = mask_q & ~(LinesPerRegion'(1) << low_idx);
  assign full_addr = {{srp_pkg::DataW{1'b0}}, tag_q, low_idx, {LineOffsetBits{1'b0}}};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      valid_q  <= 1'b0;
    end else begin
      valid_q <= active_q;
      if (pop_o) active_q <= 1'b1;
      else if (active_q && (rest == '0)) active_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      tag_q  <= job_tag_i;
      mask_q <= job_mask_i;
    end else if (active_q) begin
      mask_q <= rest;
    end
    addr_q <= full_addr[srp_pkg::DataW-1:0];
    last_q <= (rest == '0);
  end

  assign result_valid_o     = valid_q;
  assign prefetch_address_o = addr_q;
  assign last_in_run_o      = valid_q && last_q;

endmodule

`default_nettype wire

### rtl/spatial_region_prefetcher.sv
// A miss is scanned one table entry per cycle, updated and evaluated; a
// covered region goes as a job to the emitter, whose registered beats
// follow one per cycle, up to LinesPerRegion - 1 per run. busy is high
// until the miss is done, also while a push waits on a full queue, so a
// new miss is taken only once busy is low. Results are strobed and never
// stall. Reset clears all table entries and sets coverage_threshold to 8.
`default_nettype none

module spatial_region_prefetcher #(
  parameter int TableEntries   = srp_pkg::TableEntriesDef,
  parameter int LinesPerRegion = srp_pkg::LinesPerRegionDef,
  parameter int LineOffsetBits = srp_pkg::LineOffsetBitsDef,
  parameter int AddrBits       = srp_pkg::AddrBitsDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [srp_pkg::PaddrW-1:0]   paddr,
  input  wire logic [srp_pkg::DataW-1:0]    pwdata,
  output logic      [srp_pkg::DataW-1:0]    prdata,
  output logic                              pready,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [srp_pkg::DataW-1:0]    miss_address_i,
  output logic                              result_valid_o,
  output logic      [srp_pkg::DataW-1:0]    prefetch_address_o,
  output logic                              last_in_run_o
);

  localparam int RegionBits = $clog2(LinesPerRegion);
  localparam int TagW       = AddrBits - LineOffsetBits - RegionBits;
  localparam int JobW       = TagW + LinesPerRegion;

  logic [srp_pkg::ThrW-1:0]  threshold_q;
  logic                      cfg_write;
  srp_pkg::queue_status_t    qstat;
  logic                      push, pop;
  logic [TagW-1:0]           fe_tag, be_tag;
  logic [LinesPerRegion-1:0] fe_mask, be_mask;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite &&
                     (paddr[srp_pkg::PaddrW-1] == srp_pkg::CfgThresholdIdx);
  assign prdata    = (paddr[srp_pkg::PaddrW-1] == srp_pkg::CfgThresholdIdx)
                     ? {{(srp_pkg::DataW-srp_pkg::ThrW){1'b0}}, threshold_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= srp_pkg::ThresholdReset;
    end else if (cfg_write) begin
      threshold_q <= pwdata[srp_pkg::ThrW-1:0];
    end
  end

  srp_front #(
    .TableEntries   (TableEntries),
    .LinesPerRegion (LinesPerRegion),
    .LineOffsetBits (LineOffsetBits),
    .AddrBits       (AddrBits)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .miss_address_i (miss_address_i),
    .threshold_i    (threshold_q),
    .qstat_i        (qstat),
    .push_o         (push),
    .job_tag_o      (fe_tag),
    .job_mask_o     (fe_mask),
    .busy_o         (busy)
  );

  srp_queue #(
    .Width (JobW)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .data_i   ({fe_tag, fe_mask}),
    .pop_i    (pop),
    .data_o   ({be_tag, be_mask}),
    .status_o (qstat)
  );

  srp_back #(
    .LinesPerRegion (LinesPerRegion),
    .LineOffsetBits (LineOffsetBits),
    .AddrBits       (AddrBits)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .qstat_i            (qstat),
    .job_tag_i          (be_tag),
    .job_mask_i         (be_mask),
    .pop_o              (pop),
    .result_valid_o     (result_valid_o),
    .prefetch_address_o (prefetch_address_o),
    .last_in_run_o      (last_in_run_o)
  );

endmodule

`default_nettype wire

### sim/spatial_region_prefetcher_test.sv
// Self-checking testbench for spatial_region_prefetcher: miss beats in, prefetch beats out,
// checked against an in-bench model of the region table and coverage threshold.
// Depends on srp_pkg and the spatial_region_prefetcher RTL only.
module spatial_region_prefetcher_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TableEntries   = srp_pkg::TableEntriesDef;
  localparam int LinesPerRegion = srp_pkg::LinesPerRegionDef;
  localparam int LineOffsetBits = srp_pkg::LineOffsetBitsDef;
  localparam int AddrBits       = srp_pkg::AddrBitsDef;
  localparam int DataW          = srp_pkg::DataW;
  localparam int ThrW           = srp_pkg::ThrW;
  localparam int PaddrW         = srp_pkg::PaddrW;
  localparam int RegionBits     = $clog2(LinesPerRegion);
  localparam int TagW           = AddrBits - LineOffsetBits - RegionBits;

  localparam logic [PaddrW-1:0] ThresholdAddr =
    PaddrW'(4 * int'(srp_pkg::CfgThresholdIdx));
  localparam logic [PaddrW-1:0] UnmappedAddr  =
    PaddrW'(4 * (int'(srp_pkg::CfgThresholdIdx) + 1));

  localparam int ResetCycles  = 5;
  localparam int DrainCycles  = TableEntries + LinesPerRegion + 32;
  localparam int RegionPool   = 20;
  localparam int RandomPhases = 6;
  localparam int PhaseItems   = 30;

  typedef struct packed {
    logic [DataW-1:0] line_addr;
    logic             is_last;
  } prefetch_beat_t;

  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              psel           = 1'b0;
  logic              penable        = 1'b0;
  logic              pwrite         = 1'b0;
  logic [PaddrW-1:0] paddr          = '0;
  logic [DataW-1:0]  pwdata         = '0;
  logic [DataW-1:0]  prdata;
  logic              pready;
  logic              start          = 1'b0;
  logic              busy;
  logic [DataW-1:0]  miss_address_i = '0;
  logic              result_valid_o;
  logic [DataW-1:0]  prefetch_address_o;
  logic              last_in_run_o;

  // Model of the region table
  logic                      region_valid [TableEntries];
  logic [TagW-1:0]           region_tags  [TableEntries];
  logic [LinesPerRegion-1:0] region_lines [TableEntries];
  logic [31:0]               region_stamp [TableEntries];
  logic [31:0]               stamp_counter;
  logic [ThrW-1:0]           threshold_model;

  prefetch_beat_t pending_prefetches [$];
  prefetch_beat_t oldest_beat;
  int             mismatch_count = 0;
  logic           idle_gaps_on   = 1'b1;

  spatial_region_prefetcher dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .start              (start),
    .busy               (busy),
    .miss_address_i     (miss_address_i),
    .result_valid_o     (result_valid_o),
    .prefetch_address_o (prefetch_address_o),
    .last_in_run_o      (last_in_run_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic logic [DataW-1:0] region_addr(input logic [TagW-1:0] tag, input int line);
    return {tag, RegionBits'(line), LineOffsetBits'($urandom())};
  endfunction

  task automatic predict_prefetch(input logic [DataW-1:0] addr);
    logic [TagW-1:0]           tag;
    logic [RegionBits-1:0]     line;
    logic [LinesPerRegion-1:0] lines;
    int                        slot;
    int                        last_unset;
    prefetch_beat_t            beat;
    tag  = addr[AddrBits-1 -: TagW];
    line = addr[LineOffsetBits +: RegionBits];
    slot = -1;
    for (int i = 0; i < TableEntries; i++) begin
      if (slot < 0 && region_valid[i] && region_tags[i] == tag) slot = i;
    end
    if (slot < 0) begin
      for (int i = 0; i < TableEntries; i++) begin
        if (slot < 0 && !region_valid[i]) slot = i;
      end
      // Table full: evict the smallest stamp, lowest index on ties
      if (slot < 0) begin
        slot = 0;
        for (int i = 1; i < TableEntries; i++) begin
          if (region_stamp[i] < region_stamp[slot]) slot = i;
        end
      end
      region_valid[slot] = 1'b1;
      region_tags[slot]  = tag;
      region_lines[slot] = '0;
    end
    region_lines[slot][line] = 1'b1;
    stamp_counter      = stamp_counter + 32'd1;
    region_stamp[slot] = stamp_counter;
    lines = region_lines[slot];
    if ($countones(lines) >= int'(threshold_model)) begin
      last_unset = -1;
      for (int b = 0; b < LinesPerRegion; b++) begin
        if (!lines[b]) last_unset = b;
      end
      for (int b = 0; b < LinesPerRegion; b++) begin
        if (!lines[b]) begin
          beat.line_addr = {tag, RegionBits'(b), {LineOffsetBits{1'b0}}};
          beat.is_last   = (b == last_unset);
          pending_prefetches = {pending_prefetches, beat};
          region_lines[slot][b] = 1'b1;
        end
      end
    end
  endtask

  // Leave start high on return so a following beat goes out back to back;
  // the caller either sends again or drops start in the same step.
  task automatic send_miss(input logic [DataW-1:0] addr);
    start          <= 1'b1;
    miss_address_i <= addr;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_prefetch(addr);
    if (idle_gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
  endtask

  task automatic wait_prefetch_drain();
    start <= 1'b0;
    while (pending_prefetches.size() != 0 || busy) @(posedge clk_i);
    // Hold off until a miss that emits nothing has surely left the pipeline
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_config(input logic [PaddrW-1:0] addr, input logic [ThrW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {(DataW-ThrW)'($urandom()), value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (addr == ThresholdAddr) threshold_model = value;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic read_back_threshold();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ThresholdAddr;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== DataW'(threshold_model)) begin
      $display("%0t: coverage_threshold read expected %h actual %h",
               $time, DataW'(threshold_model), prdata);
      mismatch_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Default threshold: the eighth touched line of a region triggers the rest
  task automatic test_reset_threshold();
    read_back_threshold();
    send_miss('0);
    for (int i = 1; i < 8; i++) send_miss(region_addr('0, i));
    wait_prefetch_drain();
  endtask

  task automatic test_threshold_extremes();
    // Zero threshold: the first miss prefetches every other line
    write_config(ThresholdAddr, '0);
    read_back_threshold();
    send_miss('1);
    // Region already covered: emits nothing
    send_miss(region_addr('1, 3));
    wait_prefetch_drain();
    write_config(ThresholdAddr, ThrW'(1));
    // Unmapped register: drop the write, threshold stays
    write_config(UnmappedAddr, '1);
    read_back_threshold();
    send_miss(region_addr({TagW/2{2'b10}}, LinesPerRegion - 1));
    wait_prefetch_drain();
    // Threshold beyond the region size never fires
    write_config(ThresholdAddr, '1);
    read_back_threshold();
    send_miss(region_addr({TagW/2{2'b01}}, 0));
    wait_prefetch_drain();
  endtask

  task automatic test_region_replacement();
    write_config(ThresholdAddr, ThrW'(2));
    for (int k = 0; k <= TableEntries; k++) send_miss(region_addr(TagW'(256 + k), 0));
    // The oldest region was evicted and starts over; a newer one still hits
    send_miss(region_addr(TagW'(256), 5));
    send_miss(region_addr(TagW'(258), 5));
    wait_prefetch_drain();
  endtask

  task automatic test_random_traffic();
    logic [TagW-1:0] tag_pool [RegionPool];
    logic [TagW-1:0] tag;
    logic [ThrW-1:0] thr;
    logic            sweep;
    int              accepted;
    int              burst_len;
    int              first_line;
    for (int i = 0; i < RegionPool; i++) tag_pool[i] = TagW'($urandom());
    for (int phase = 0; phase < RandomPhases; phase++) begin
      if (phase == 0) thr = ThrW'(LinesPerRegion);
      else if (phase == 1) thr = ThrW'($urandom_range(0, 31));
      else if (phase == RandomPhases - 1) thr = srp_pkg::ThresholdReset;
      else thr = ThrW'($urandom_range(1, LinesPerRegion));
      write_config(ThresholdAddr, thr);
      idle_gaps_on = (phase != RandomPhases - 1);
      accepted = 0;
      while (accepted < PhaseItems) begin
        if ($urandom_range(0, 4) == 0) begin
          send_miss($urandom());
          accepted++;
        end else begin
          // Burst of misses into one region: a sweep or scattered lines
          tag        = tag_pool[$urandom_range(0, RegionPool - 1)];
          burst_len  = $urandom_range(1, LinesPerRegion);
          sweep      = 1'($urandom_range(0, 1));
          first_line = $urandom_range(0, LinesPerRegion - 1);
          for (int k = 0; k < burst_len; k++) begin
            send_miss(region_addr(tag, sweep ? (first_line + k) % LinesPerRegion
                                             : $urandom_range(0, LinesPerRegion - 1)));
          end
          accepted += burst_len;
        end
      end
      wait_prefetch_drain();
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (pending_prefetches.size() == 0) begin
        $display("%0t: unexpected prefetch beat, expected none, actual %h last %b",
                 $time, prefetch_address_o, last_in_run_o);
        mismatch_count++;
      end else begin
        oldest_beat = pending_prefetches.pop_front();
        if (prefetch_address_o !== oldest_beat.line_addr) begin
          $display("%0t: prefetch_address expected %h actual %h",
                   $time, oldest_beat.line_addr, prefetch_address_o);
          mismatch_count++;
        end
        if (last_in_run_o !== oldest_beat.is_last) begin
          $display("%0t: last_in_run expected %b actual %b",
                   $time, oldest_beat.is_last, last_in_run_o);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    for (int i = 0; i < TableEntries; i++) begin
      region_valid[i] = 1'b0;
      region_tags[i]  = '0;
      region_lines[i] = '0;
      region_stamp[i] = '0;
    end
    stamp_counter   = '0;
    threshold_model = srp_pkg::ThresholdReset;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_threshold();
    test_threshold_extremes();
    test_region_replacement();
    test_random_traffic();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### files.f
rtl/srp_pkg.sv
rtl/srp_front.sv
rtl/srp_queue.sv
rtl/srp_back.sv
rtl/spatial_region_prefetcher.sv
sim/spatial_region_prefetcher_test.sv
